[rtl/rpn_pkg.sv]
// Package for the RPN stack evaluator: action and fault codes, cell commands,
// controller states and stack sizing. No dependencies.
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_OUT_W = 7;
  localparam int DATA_W      = 32;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_PEEK = 3'd5,
    ACT_POP  = 3'd6,
    ACT_SWAP = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_DIV0  = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_ABOVE = 2'd1,
    CELL_FROM_BELOW = 2'd2
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MUL    = 2'd1,
    ST_DIV    = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

endpackage

[rtl/rpn_token_if.sv]
// Token channel of the RPN stack evaluator: valid/ready plus action and literal.
// Depends on rpn_pkg.
interface rpn_token_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               action;
  logic signed [DATA_W-1:0] literal;

  modport source (output valid, action, literal, input ready);
  modport sink   (input valid, action, literal, output ready);
endinterface

[rtl/rpn_result_if.sv]
// Result channel of the RPN stack evaluator: valid/ready plus shown value,
// depth and fault. Depends on rpn_pkg.
interface rpn_result_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     shown;
  logic signed [DATA_W-1:0] shown_value;
  logic [DEPTH_OUT_W-1:0]   stack_depth;
  logic [1:0]               fault;

  modport source (output valid, shown, shown_value, stack_depth, fault, input ready);
  modport sink   (input valid, shown, shown_value, stack_depth, fault, output ready);
endinterface

[rtl/rpn_cell.sv]
// One stack entry: holds, or takes the entry above or below it.
// Depends on rpn_pkg.
module rpn_cell import rpn_pkg::*; (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] above,
  input  logic [DATA_W-1:0] below,
  output logic [DATA_W-1:0] value
);

  always_ff @(posedge clk) begin
    unique case (cmd)
      CELL_FROM_ABOVE: value <= above;
      CELL_FROM_BELOW: value <= below;
      default:         value <= value;
    endcase
  end

endmodule

[rtl/rpn_divider.sv]
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on rpn_pkg.
module rpn_divider import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] ud;
  logic              neg;
  logic [DATA_W:0]   rem_t;
  logic              fits;

  assign rem_t    = {rem, quo[DATA_W-1]};
  assign fits     = rem_t >= {1'b0, ud};
  assign done     = busy && (cnt == CNT_W'(DATA_W - 1));
  assign quotient = neg ? (~quo + DATA_W'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !done;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
      ud  <= den[DATA_W-1] ? (~den + DATA_W'(1)) : den;
      neg <= num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy) begin
      // restoring step: shift in next dividend bit, subtract when it fits
      rem <= fits ? DATA_W'(rem_t - {1'b0, ud}) : rem_t[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

endmodule

[rtl/rpn_stack_evaluator_core.sv]
// RPN stack evaluator top level: token channel in, result channel out.
// Depends on rpn_pkg, rpn_token_if, rpn_result_if, rpn_cell, rpn_divider.
//
// Each token on the token channel (action, literal) gives exactly one item on
// the result channel: shown flag and value for peek or pop, the stack depth
// after the token and a fault code. The stack is a row of STACK_DEPTH cells,
// cell 0 being the top; push shifts every entry down one cell, pop and binary
// operations shift them up, swap exchanges the top two cells.
// A token is taken only while the controller is idle. Push, add, subtract,
// peek, pop, swap and a faulting divide go straight to the commit state;
// multiply passes the product register state first, and divide waits in the
// divide state for the bit-serial divider. The controller returns to idle as
// the result is registered, and only then takes the next token.
// The result register is written when the previous result has gone; while
// the receiver stalls a finished token waits in the commit state and no new
// token is taken. Reset clears the depth count and the valid flags; the cell
// contents are not reset, as only entries below the depth are read.
module rpn_stack_evaluator_core import rpn_pkg::*; (
  input logic         clk,
  input logic         rst,
  rpn_token_if.sink   token,
  rpn_result_if.source result
);

  state_t             state, state_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  action_t            act;
  logic [DATA_W-1:0]  lit;
  logic [DATA_W-1:0]  product;
  logic [DATA_W-1:0]  quotient;
  logic               div_start;
  logic               div_done;

  logic [DATA_W-1:0]  cell_val [STACK_DEPTH];
  logic [DATA_W-1:0]  cell_above [STACK_DEPTH];
  logic [DATA_W-1:0]  cell_below [STACK_DEPTH];
  cell_cmd_t          cell_cmd [STACK_DEPTH];

  logic [DATA_W-1:0]  top, second, top_in, arith;
  logic               commit;
  logic               binary, under, over;
  fault_t             fault;

  assign top    = cell_val[0];
  assign second = cell_val[1];

  // chain of cells
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      assign cell_above[i] = top_in;
    end else begin : g_mid
      assign cell_above[i] = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign cell_below[i] = '0;
    end else begin : g_up
      assign cell_below[i] = cell_val[i+1];
    end
    rpn_cell u_cell (
      .clk   (clk),
      .cmd   (cell_cmd[i]),
      .above (cell_above[i]),
      .below (cell_below[i]),
      .value (cell_val[i])
    );
  end

  rpn_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (second),
    .den      (top),
    .done     (div_done),
    .quotient (quotient)
  );

  // fault and result of the held token
  always_comb begin
    binary = (act == ACT_ADD) || (act == ACT_SUB) || (act == ACT_MUL) ||
             (act == ACT_DIV) || (act == ACT_SWAP);
    under  = (binary && (depth < DEPTH_W'(2))) ||
             (((act == ACT_PEEK) || (act == ACT_POP)) && (depth == '0));
    over   = (act == ACT_PUSH) && (depth == DEPTH_W'(STACK_DEPTH));
    priority if (under)                          fault = FAULT_UNDER;
    else if (over)                               fault = FAULT_OVER;
    else if ((act == ACT_DIV) && (top == '0))    fault = FAULT_DIV0;
    else                                         fault = FAULT_NONE;

    unique case (act)
      ACT_ADD: arith = second + top;
      ACT_SUB: arith = second - top;
      ACT_MUL: arith = product;
      default: arith = quotient;
    endcase
    top_in = (act == ACT_PUSH) ? lit : arith;
  end

  assign commit = (state == ST_FINISH) && (!result.valid || result.ready);

  // cell commands and depth update, only on commit without fault
  always_comb begin
    depth_next = depth;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_cmd[i] = CELL_HOLD;
    end
    if (commit && (fault == FAULT_NONE)) begin
      unique case (act)
        ACT_PUSH: begin
          for (int i = 0; i < STACK_DEPTH; i++) cell_cmd[i] = CELL_FROM_ABOVE;
          depth_next = depth + DEPTH_W'(1);
        end
        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
          for (int i = 1; i < STACK_DEPTH; i++) cell_cmd[i] = CELL_FROM_BELOW;
          cell_cmd[0] = CELL_FROM_ABOVE;
          depth_next  = depth - DEPTH_W'(1);
        end
        ACT_POP: begin
          for (int i = 0; i < STACK_DEPTH; i++) cell_cmd[i] = CELL_FROM_BELOW;
          depth_next = depth - DEPTH_W'(1);
        end
        ACT_SWAP: begin
          cell_cmd[0] = CELL_FROM_BELOW;
          cell_cmd[1] = CELL_FROM_ABOVE;
        end
        default: ;
      endcase
    end
  end

  // controller
  always_comb begin
    state_next  = state;
    token.ready = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        token.ready = 1'b1;
        if (token.valid) begin
          priority if (action_t'(token.action) == ACT_MUL) begin
            state_next = ST_MUL;
          end else if ((action_t'(token.action) == ACT_DIV) &&
                       (depth >= DEPTH_W'(2)) && (top != '0)) begin
            state_next = ST_DIV;
            div_start  = 1'b1;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_MUL:    state_next = ST_FINISH;
      ST_DIV:    if (div_done) state_next = ST_FINISH;
      ST_FINISH: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      depth <= '0;
    end else begin
      state <= state_next;
      depth <= depth_next;
    end
  end

  // token hold and product register
  always_ff @(posedge clk) begin
    if (token.valid && token.ready) begin
      act <= action_t'(token.action);
      lit <= token.literal;
    end
    if (state == ST_MUL) begin
      product <= DATA_W'(second * top);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.shown       <= (fault == FAULT_NONE) &&
                            ((act == ACT_PEEK) || (act == ACT_POP));
      result.shown_value <= ((fault == FAULT_NONE) &&
                             ((act == ACT_PEEK) || (act == ACT_POP))) ? top : '0;
      result.stack_depth <= DEPTH_OUT_W'(depth_next);
      result.fault       <= fault;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && (act == ACT_PUSH) && (fault == FAULT_NONE)) |=>
      (depth == $past(depth) + DEPTH_W'(1)))
    else $error("push did not grow the stack");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.fault == FAULT_OVER)) |->
      (result.stack_depth == DEPTH_OUT_W'(STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");
`endif

endmodule

[tb/sv/tb_rpn_stack_evaluator_core.sv]
// Testbench for rpn_stack_evaluator_core: drives tokens with random gaps, predicts
// every result from its own copy of the stack and checks each one field by field.
// Depends on rpn_pkg, rpn_token_if, rpn_result_if and the core itself.
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator_core;
  import rpn_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    logic                   shown;
    logic [DATA_W-1:0]      value;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [1:0]             fault;
  } calc_result_t;

  class calc_scoreboard;
    logic [DATA_W-1:0] cells [STACK_DEPTH];
    int unsigned       depth;
    calc_result_t      expected_q[$];
    int unsigned       errors;

    function new();
      depth  = 0;
      errors = 0;
    endfunction

    // Signed division, truncating toward zero; most negative / -1 wraps.
    function logic [DATA_W-1:0] quotient_trunc(input logic [DATA_W-1:0] num,
                                               input logic [DATA_W-1:0] den);
      logic [DATA_W-1:0] un, ud, q;
      un = num[DATA_W-1] ? -num : num;
      ud = den[DATA_W-1] ? -den : den;
      q  = un / ud;
      return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
    endfunction

    function void note_token(input action_t act, input logic [DATA_W-1:0] lit);
      calc_result_t      exp_r;
      logic [DATA_W-1:0] rhs, lhs, res;
      exp_r = '{shown: 1'b0, value: '0, depth: '0, fault: FAULT_NONE};
      case (act)
        ACT_PUSH: begin
          if (depth >= STACK_DEPTH) exp_r.fault = FAULT_OVER;
          else begin
            cells[depth] = lit;
            depth++;
          end
        end
        ACT_PEEK, ACT_POP: begin
          if (depth == 0) exp_r.fault = FAULT_UNDER;
          else begin
            exp_r.shown = 1'b1;
            exp_r.value = cells[depth-1];
            if (act == ACT_POP) depth--;
          end
        end
        default: begin
          if (depth < 2) exp_r.fault = FAULT_UNDER;
          else begin
            rhs = cells[depth-1];
            lhs = cells[depth-2];
            if (act == ACT_SWAP) begin
              cells[depth-1] = lhs;
              cells[depth-2] = rhs;
            end else if (act == ACT_DIV && rhs == '0) begin
              exp_r.fault = FAULT_DIV0;
            end else begin
              case (act)
                ACT_ADD: res = lhs + rhs;
                ACT_SUB: res = lhs - rhs;
                ACT_MUL: res = lhs * rhs;
                default: res = quotient_trunc(lhs, rhs);
              endcase
              cells[depth-2] = res;
              depth--;
            end
          end
        end
      endcase
      exp_r.depth = DEPTH_OUT_W'(depth);
      expected_q.push_back(exp_r);
    endfunction

    function void report(input string field, input logic [DATA_W-1:0] exp_v,
                         input logic [DATA_W-1:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $error("%s mismatch: expected %0h, actual %0h", field, exp_v, got_v);
    endfunction

    function void check_result(input calc_result_t got);
      calc_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("result item arrived with no token outstanding");
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.shown !== exp_r.shown) report("shown", exp_r.shown, got.shown);
      if (got.value !== exp_r.value) report("shown_value", exp_r.value, got.value);
      if (got.depth !== exp_r.depth) report("stack_depth", exp_r.depth, got.depth);
      if (got.fault !== exp_r.fault) report("fault", exp_r.fault, got.fault);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet_mode;
  int unsigned cycle_count;
  calc_scoreboard sb = new();

  rpn_token_if  token_ch();
  rpn_result_if result_ch();

  rpn_stack_evaluator_core dut (
    .clk    (clk),
    .rst    (rst),
    .token  (token_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mix extremes, zero and small values in with full-range random ones.
  function automatic logic [DATA_W-1:0] pick_literal();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return '1;
      4:       return 32'd1;
      5, 6:    return DATA_W'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed programs: push when shallow, operate when deep.
  function automatic action_t pick_action(input int unsigned depth);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return action_t'($urandom_range(0, 7));
    if (depth == 0) return ACT_PUSH;
    if (depth == 1) return (r < 75) ? ACT_PUSH : ((r < 88) ? ACT_PEEK : ACT_POP);
    if (depth >= STACK_DEPTH - 2 && r < 70) return ACT_ADD;
    if (r < 36) return ACT_PUSH;
    if (r < 46) return ACT_ADD;
    if (r < 56) return ACT_SUB;
    if (r < 66) return ACT_MUL;
    if (r < 78) return ACT_DIV;
    if (r < 85) return ACT_PEEK;
    if (r < 92) return ACT_POP;
    return ACT_SWAP;
  endfunction

  task automatic send_token(input action_t act, input logic [DATA_W-1:0] lit);
    int gap;
    if ($urandom_range(0, 59) == 0) quiet_mode = !quiet_mode;
    gap = quiet_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      token_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token_ch.valid   <= 1'b1;
    token_ch.action  <= act;
    token_ch.literal <= lit;
    do @(posedge clk); while (!token_ch.ready);
    sb.note_token(act, lit);
  endtask

  initial begin : token_source
    action_t act;
    int      n;
    token_ch.valid   <= 1'b0;
    token_ch.action  <= ACT_PUSH;
    token_ch.literal <= '0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Underflow on an empty and a one-deep stack, wrap, min / -1, divide by zero.
    send_token(ACT_POP,  $urandom());
    send_token(ACT_PEEK, $urandom());
    send_token(ACT_ADD,  $urandom());
    send_token(ACT_SWAP, $urandom());
    send_token(ACT_PUSH, 32'h7fff_ffff);
    send_token(ACT_SWAP, $urandom());
    send_token(ACT_DIV,  $urandom());
    send_token(ACT_PUSH, 32'd1);
    send_token(ACT_ADD,  $urandom());
    send_token(ACT_PEEK, $urandom());
    send_token(ACT_PUSH, '1);
    send_token(ACT_DIV,  $urandom());
    send_token(ACT_PUSH, '0);
    send_token(ACT_DIV,  $urandom());
    send_token(ACT_POP,  $urandom());
    send_token(ACT_PUSH, 32'd7);
    send_token(ACT_PUSH, -32'sd2);
    send_token(ACT_SWAP, $urandom());
    send_token(ACT_SUB,  $urandom());
    send_token(ACT_PUSH, 32'h8000_0001);
    send_token(ACT_MUL,  $urandom());
    send_token(ACT_PUSH, -32'sd5);
    send_token(ACT_DIV,  $urandom());
    send_token(ACT_POP,  $urandom());
    send_token(ACT_POP,  $urandom());

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 400 == 100) begin
        // Fill past the top to hit overflow, then drain past the bottom.
        while (sb.depth < STACK_DEPTH) send_token(ACT_PUSH, pick_literal());
        send_token(ACT_PUSH, pick_literal());
        send_token(ACT_PUSH, pick_literal());
        while (sb.depth > 0) send_token(ACT_POP, $urandom());
        send_token(ACT_POP,  $urandom());
        send_token(ACT_PEEK, $urandom());
      end else begin
        act = pick_action(sb.depth);
        send_token(act, (act == ACT_PUSH) ? pick_literal() : $urandom());
      end
    end
    token_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int           stall;
    calc_result_t got;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      got.shown = result_ch.shown;
      got.value = result_ch.shown_value;
      got.depth = result_ch.stack_depth;
      got.fault = result_ch.fault;
      sb.check_result(got);
    end
  end

endmodule
